// File: hw/rtl/uer_pkg.sv
package uer_pkg;

  // Field and state widths
  localparam int unsigned TimeW      = 32;
  localparam int unsigned PeriodW    = 20;
  localparam int unsigned MaxValidW  = 16;
  localparam int unsigned PollW      = 17;
  localparam int unsigned TrigW      = 8;
  localparam int unsigned DelayW     = 16;
  localparam int unsigned IdW        = 8;

  // Configuration port
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD     = 8'd0,
    CFG_MAX_VALID  = 8'd1,
    CFG_POLL       = 8'd2,
    CFG_TRIG_WIDTH = 8'd3
  } cfg_idx_e;

  // Register reset values
  localparam logic [PeriodW-1:0]   PeriodRst    = 20'd150000;
  localparam logic [MaxValidW-1:0] MaxValidRst  = 16'd9300;
  localparam logic [PollW-1:0]     PollRst      = 17'd10000;
  localparam logic [TrigW-1:0]     TrigWidthRst = 8'd12;

endpackage

// File: hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: one input beat per microsecond tick of the echo pin.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle while out_stall_i is low; the single-pass update between
// the two registers (32-bit elapsed-time subtract and compare) sets the cycle.
// Reset: asynchronous, active low; clears all timing state and loads the register defaults.
module ultrasonic_echo_ranger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          echo_level_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trigger_level_o,
  output logic                          new_sample_o,
  output logic [uer_pkg::DelayW-1:0]    echo_delay_o,
  output logic [uer_pkg::IdW-1:0]       sample_id_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [uer_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Configuration registers
  logic [uer_pkg::PeriodW-1:0]   period_q;
  logic [uer_pkg::MaxValidW-1:0] max_valid_q;
  logic [uer_pkg::PollW-1:0]     poll_int_q;
  logic [uer_pkg::TrigW-1:0]     trig_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= uer_pkg::PeriodRst;
      max_valid_q  <= uer_pkg::MaxValidRst;
      poll_int_q   <= uer_pkg::PollRst;
      trig_width_q <= uer_pkg::TrigWidthRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        uer_pkg::CFG_PERIOD:     period_q     <= cfg_data_i[uer_pkg::PeriodW-1:0];
        uer_pkg::CFG_MAX_VALID:  max_valid_q  <= cfg_data_i[uer_pkg::MaxValidW-1:0];
        uer_pkg::CFG_POLL:       poll_int_q   <= cfg_data_i[uer_pkg::PollW-1:0];
        uer_pkg::CFG_TRIG_WIDTH: trig_width_q <= cfg_data_i[uer_pkg::TrigW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input register feeds the result register
  logic in_valid_q;
  logic echo_q;
  logic out_valid_q;
  logic out_take;
  logic proc;

  assign out_take   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_take;
  assign in_stall_o = in_valid_q && !out_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      echo_q <= echo_level_i;
    end
  end

  // Timing state
  logic [uer_pkg::TimeW-1:0]  time_q, time_d;
  logic [uer_pkg::TimeW-1:0]  last_trig_q, last_trig_d;
  logic [uer_pkg::TimeW-1:0]  start_q, start_d;
  logic [uer_pkg::TimeW-1:0]  width_q, width_d;
  logic                       done_q, done_d;
  logic                       prev_q;
  logic [uer_pkg::PollW-1:0]  poll_q, poll_d;
  logic [uer_pkg::TrigW-1:0]  trig_rem_q, trig_rem_d;
  logic [uer_pkg::DelayW-1:0] delay_q, delay_d;
  logic [uer_pkg::IdW-1:0]    id_q, id_d;
  logic                       trig_d, trig_q;
  logic                       fresh_d, fresh_q;

  // Per-tick update
  logic                       edge_seen;
  logic [uer_pkg::TimeW-1:0]  width_e;
  logic                       done_e;
  logic [uer_pkg::PollW:0]    poll_inc;
  logic                       poll_hit;
  logic [uer_pkg::TimeW-1:0]  elapsed;
  logic                       fire;
  logic                       finish;
  logic [uer_pkg::TimeW-2:0]  half;
  logic                       publish;
  logic [uer_pkg::TrigW-1:0]  trig_rem_f;

  always_comb begin
    // echo edges, only while no measurement is finished
    edge_seen = (echo_q != prev_q) && !done_q;
    start_d   = (edge_seen && echo_q) ? time_q : start_q;
    width_e   = (edge_seen && !echo_q) ? (time_q - start_q) : width_q;
    done_e    = (edge_seen && !echo_q) ? 1'b1 : done_q;

    // poll tick
    poll_inc = {1'b0, poll_q} + {{uer_pkg::PollW{1'b0}}, 1'b1};
    poll_hit = poll_inc >= {1'b0, poll_int_q};
    poll_d   = poll_hit ? '0 : poll_inc[uer_pkg::PollW-1:0];

    elapsed = time_q - last_trig_q;
    fire    = poll_hit &&
              (elapsed >= {{(uer_pkg::TimeW-uer_pkg::PeriodW){1'b0}}, period_q});
    finish  = poll_hit && !fire && done_e;
    half    = width_e[uer_pkg::TimeW-1:1];
    publish = finish &&
              (half < {{(uer_pkg::TimeW-1-uer_pkg::MaxValidW){1'b0}}, max_valid_q});

    last_trig_d = fire ? time_q : last_trig_q;
    width_d     = fire ? '0 : width_e;
    done_d      = (fire || finish) ? 1'b0 : done_e;
    delay_d     = publish ? half[uer_pkg::DelayW-1:0] : delay_q;
    id_d        = publish ? (id_q + {{(uer_pkg::IdW-1){1'b0}}, 1'b1}) : id_q;
    fresh_d     = publish;

    // trigger pulse countdown
    trig_rem_f = fire ? trig_width_q : trig_rem_q;
    trig_d     = trig_rem_f != '0;
    trig_rem_d = trig_d ? (trig_rem_f - {{(uer_pkg::TrigW-1){1'b0}}, 1'b1}) : trig_rem_f;

    time_d = time_q + {{(uer_pkg::TimeW-1){1'b0}}, 1'b1};
  end

  // State and result registers advance together on each processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      last_trig_q <= '0;
      start_q     <= '0;
      width_q     <= '0;
      done_q      <= 1'b0;
      prev_q      <= 1'b0;
      poll_q      <= '0;
      trig_rem_q  <= '0;
      delay_q     <= '0;
      id_q        <= '0;
      trig_q      <= 1'b0;
      fresh_q     <= 1'b0;
    end else if (proc) begin
      time_q      <= time_d;
      last_trig_q <= last_trig_d;
      start_q     <= start_d;
      width_q     <= width_d;
      done_q      <= done_d;
      prev_q      <= echo_q;
      poll_q      <= poll_d;
      trig_rem_q  <= trig_rem_d;
      delay_q     <= delay_d;
      id_q        <= id_d;
      trig_q      <= trig_d;
      fresh_q     <= fresh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= in_valid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = trig_q;
  assign new_sample_o    = fresh_q;
  assign echo_delay_o    = delay_q;
  assign sample_id_o     = id_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

  typedef logic [uer_pkg::CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [uer_pkg::CfgDataW-1:0] cfg_data_t;

  // Index outside the register list; a write to it must change nothing
  localparam cfg_idx_t CfgIdxSpare = 8'hFF;
  // Echo levels for the edge test, sent MSB first
  localparam logic [12:0] EdgePattern = 13'b1000111110010;

  typedef struct packed {
    logic                       trig;
    logic                       fresh;
    logic [uer_pkg::DelayW-1:0] delay;
    logic [uer_pkg::IdW-1:0]    id;
  } ranger_out_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic                       echo_level = 1'b0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic                       trigger_level;
  logic                       new_sample;
  logic [uer_pkg::DelayW-1:0] echo_delay;
  logic [uer_pkg::IdW-1:0]    sample_id;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  cfg_idx_t                   cfg_index  = '0;
  cfg_data_t                  cfg_data   = '0;

  // Idle rates and the long receiver hold-off
  int send_gap_pct   = 0;
  int out_stall_pct  = 0;
  int hold_off_left  = 0;

  int fail_count     = 0;
  int ticks_checked  = 0;
  int samples_seen   = 0;
  int trigger_ticks  = 0;
  int settings_used  = 0;

  ranger_out_t expected_ticks[$];

  // Ranger state as predicted
  logic [uer_pkg::PeriodW-1:0]   m_period;
  logic [uer_pkg::MaxValidW-1:0] m_max_valid;
  logic [uer_pkg::PollW-1:0]     m_poll_interval;
  logic [uer_pkg::TrigW-1:0]     m_trig_width;
  logic [uer_pkg::TimeW-1:0]     m_time;
  logic [uer_pkg::TimeW-1:0]     m_last_trig;
  logic [uer_pkg::TimeW-1:0]     m_echo_start;
  logic [uer_pkg::TimeW-1:0]     m_echo_width;
  logic                          m_echo_done;
  logic                          m_prev_echo;
  logic [uer_pkg::PollW-1:0]     m_poll_count;
  logic [uer_pkg::TrigW-1:0]     m_trig_left;
  logic [uer_pkg::DelayW-1:0]    m_delay;
  logic [uer_pkg::IdW-1:0]       m_id;

  ultrasonic_echo_ranger dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .echo_level_i    (echo_level),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .trigger_level_o (trigger_level),
    .new_sample_o    (new_sample),
    .echo_delay_o    (echo_delay),
    .sample_id_o     (sample_id),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Generous overall limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void reset_ranger();
    m_period        = uer_pkg::PeriodRst;
    m_max_valid     = uer_pkg::MaxValidRst;
    m_poll_interval = uer_pkg::PollRst;
    m_trig_width    = uer_pkg::TrigWidthRst;
    m_time          = '0;
    m_last_trig     = '0;
    m_echo_start    = '0;
    m_echo_width    = '0;
    m_echo_done     = 1'b0;
    m_prev_echo     = 1'b0;
    m_poll_count    = '0;
    m_trig_left     = '0;
    m_delay         = '0;
    m_id            = '0;
  endfunction

  function automatic void apply_register(input cfg_idx_t idx, input cfg_data_t data);
    case (idx)
      uer_pkg::CFG_PERIOD:     m_period        = data[uer_pkg::PeriodW-1:0];
      uer_pkg::CFG_MAX_VALID:  m_max_valid     = data[uer_pkg::MaxValidW-1:0];
      uer_pkg::CFG_POLL:       m_poll_interval = data[uer_pkg::PollW-1:0];
      uer_pkg::CFG_TRIG_WIDTH: m_trig_width    = data[uer_pkg::TrigW-1:0];
      default: ;
    endcase
  endfunction

  // One microsecond tick: edge timing, then poll, then trigger pin, then time
  function automatic ranger_out_t step_ranger(input logic level);
    ranger_out_t               res;
    logic [uer_pkg::TimeW-1:0] elapsed;
    logic [uer_pkg::TimeW-1:0] half;
    res = '0;
    if (level != m_prev_echo && !m_echo_done) begin
      if (level) begin
        m_echo_start = m_time;
      end else begin
        m_echo_width = m_time - m_echo_start;
        m_echo_done  = 1'b1;
      end
    end
    m_prev_echo = level;

    if ({1'b0, m_poll_count} + 18'd1 >= {1'b0, m_poll_interval}) begin
      m_poll_count = '0;
      elapsed = m_time - m_last_trig;
      if (elapsed >= 32'(m_period)) begin
        m_last_trig  = m_time;
        m_echo_width = '0;
        m_echo_done  = 1'b0;
        m_trig_left  = m_trig_width;
      end else if (m_echo_done) begin
        half = m_echo_width >> 1;
        m_echo_done = 1'b0;
        if (half < 32'(m_max_valid)) begin
          m_delay   = half[uer_pkg::DelayW-1:0];
          m_id      = m_id + 8'd1;
          res.fresh = 1'b1;
          samples_seen++;
        end
      end
    end else begin
      m_poll_count = m_poll_count + 17'd1;
    end

    res.trig = (m_trig_left != '0);
    if (res.trig) begin
      m_trig_left = m_trig_left - 8'd1;
      trigger_ticks++;
    end
    m_time    = m_time + 32'd1;
    res.delay = m_delay;
    res.id    = m_id;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on each accepted input beat, check each accepted result beat
  always @(posedge clk_i) begin : monitor
    ranger_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        expected_ticks.push_back(step_ranger(echo_level));
        ticks_checked++;
      end
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result, expected none, %s %0b %0b %0d %0d",
                   $time, "actual trig/new/delay/id", trigger_level, new_sample,
                   echo_delay, sample_id);
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("trigger_level", 16'(want.trig), 16'(trigger_level));
          check_field("new_sample", 16'(want.fresh), 16'(new_sample));
          check_field("echo_delay", want.delay, echo_delay);
          check_field("sample_id", 16'(want.id), 16'(sample_id));
        end
      end
    end
  end

  // Receiver stall, with a counted long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  // Send one echo beat; valid stays up after acceptance for the next beat
  task automatic send_echo(input logic level);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    echo_level <= level;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected beat has come out
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (expected_ticks.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_ticks.size() != 0) begin
      $display("%0t: %0d results missing, expected %0d more beats, actual 0",
               $time, expected_ticks.size(), expected_ticks.size());
      fail_count++;
      expected_ticks.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // One register write; valid is left high for a following write
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic write_single(input cfg_idx_t idx, input cfg_data_t data);
    settle();
    write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [uer_pkg::PeriodW-1:0] period,
                               input logic [uer_pkg::MaxValidW-1:0] max_valid,
                               input logic [uer_pkg::PollW-1:0] poll,
                               input logic [uer_pkg::TrigW-1:0] width);
    settle();
    write_reg(uer_pkg::CFG_PERIOD, cfg_data_t'(period));
    write_reg(uer_pkg::CFG_MAX_VALID, cfg_data_t'(max_valid));
    write_reg(uer_pkg::CFG_POLL, cfg_data_t'(poll));
    write_reg(uer_pkg::CFG_TRIG_WIDTH, cfg_data_t'(width));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly echo pulses of random low and high lengths, some noise bursts
  task automatic run_echo_traffic(input int n_items, input int max_low, input int max_high,
                                  input int noise_pct);
    int sent;
    int low_len;
    int high_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < noise_pct) begin
        repeat ($urandom_range(1, 8)) begin
          send_echo(1'($urandom_range(1)));
          sent++;
        end
      end else begin
        low_len  = $urandom_range(max_low);
        high_len = $urandom_range(1, max_high);
        repeat (low_len) begin
          send_echo(1'b0);
          sent++;
        end
        repeat (high_len) begin
          send_echo(1'b1);
          sent++;
        end
      end
    end
  endtask

  task automatic send_levels(input logic [12:0] levels, input int count);
    for (int i = count - 1; i >= 0; i--) send_echo(levels[i]);
  endtask

  // Default registers straight after reset
  task automatic test_reset_defaults();
    send_levels(13'b101, 3);
  endtask

  // Zero interval polls every tick, zero period fires on every poll, zero width no pulse
  task automatic test_zero_settings();
    load_settings('0, 16'd5, '0, '0);
    send_levels(13'b1010, 4);
  endtask

  task automatic test_minimum_settings();
    load_settings(20'd1, 16'd1, 17'd1, 8'd1);
    send_levels(13'b1010, 4);
  endtask

  // Short pulse published, edges while done dropped, long pulse over the limit dropped
  task automatic test_echo_edges();
    load_settings(20'd6, 16'd2, 17'd3, 8'd2);
    send_levels(EdgePattern, 13);
  endtask

  task automatic test_spare_index();
    write_single(CfgIdxSpare, '1);
    send_levels(13'b10, 2);
  endtask

  task automatic test_maximum_settings();
    load_settings(20'd1000000, 16'hFFFF, 17'd100000, 8'd255);
    send_levels(13'b100, 3);
  endtask

  // Interval lowered below the running count polls at once
  task automatic test_poll_lowered();
    write_single(uer_pkg::CFG_POLL, cfg_data_t'(17'd1));
    send_levels(13'b01, 2);
  endtask

  task automatic test_traffic_sender_idle();
    load_settings(20'd40, 16'd10, 17'd4, 8'd3);
    run_echo_traffic(220, 30, 24, 15);
  endtask

  task automatic test_traffic_receiver_idle();
    int period;
    int max_valid;
    int poll;
    int width;
    period    = $urandom_range(1, 120);
    max_valid = $urandom_range(1, 40);
    poll      = $urandom_range(1, 10);
    width     = $urandom_range(1, 8);
    load_settings(20'(period), 16'(max_valid), 17'(poll), 8'(width));
    run_echo_traffic(220, 40, 2 * max_valid + 6, 20);
  endtask

  task automatic test_traffic_full_rate();
    load_settings(20'd300, 16'hFFFF, 17'd2, 8'd255);
    run_echo_traffic(240, 20, 60, 10);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    load_settings(20'd25, 16'd7, 17'd3, 8'd2);
    hold_off_left = 150;
    run_echo_traffic(80, 10, 16, 10);
  endtask

  initial begin
    reset_ranger();
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_gap_pct  = 30;
    out_stall_pct = 70;
    test_reset_defaults();
    test_zero_settings();
    test_minimum_settings();
    test_echo_edges();
    test_spare_index();
    test_maximum_settings();
    test_poll_lowered();
    test_traffic_sender_idle();

    send_gap_pct  = 70;
    out_stall_pct = 30;
    test_traffic_receiver_idle();

    send_gap_pct  = 0;
    out_stall_pct = 0;
    test_traffic_full_rate();
    test_backpressure();
    settle();

    $display("Checked %0d ticks under %0d register settings", ticks_checked, settings_used);
    $display("Saw %0d published samples and %0d trigger-high ticks, %0d mismatches",
             samples_seen, trigger_ticks, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger.sv
test/tb.sv
